/* design/tlptq_pkg.sv */
// tlptq_pkg: shared constants for the two-level priority task queue.
// Operation codes, field widths and the default entry count.
// No dependencies.
package tlptq_pkg;

    localparam int ID_W          = 6;   // width of entry_id / served_id
    localparam int OP_W          = 2;   // width of operation
    localparam int MAX_IDS       = 64;  // entry numbers reachable through entry_id
    localparam int ENTRIES_DFLT  = 64;

    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_SERVE   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

endpackage

/* design/two_level_priority_task_queue_unit.sv */
// two_level_priority_task_queue_unit: strict-priority scheduler over two linked FIFO queues.
// Link tables are held in two synchronous memories; heads, tails and waiting marks in flops.
// Depends on tlptq_pkg.

// Usage: drive operation, entry_id and high_priority with start high; the item is taken at
// the first rising edge where busy is low. Exactly one result comes back per item, shown for
// a single cycle with done high; the receiver cannot stall it, so sample on done. Enqueue,
// a serve that finds both queues empty, a remove of an entry that is not waiting, an entry
// number at or above ENTRIES on a remove, and operation code 3 all finish from idle (done on the
// cycle after the item is taken, busy stays low). A serve that pops an entry and a remove of a
// waiting entry pass through S_EXEC: the link memories have a registered synchronous read, so the
// popped or removed entry's links arrive in S_EXEC (busy high), where the heads and
// tails are updated and the neighbors are relinked. No clearing pass follows reset: the
// waiting marks are flops that reset clears, and links are only ever read for waiting entries.
// entry_id is 6 bits wide, so at most 64 entries are addressable; ENTRIES above 64 behaves as 64.
module two_level_priority_task_queue_unit #(
    parameter int ENTRIES = tlptq_pkg::ENTRIES_DFLT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tlptq_pkg::OP_W-1:0]  operation,
    input  logic [tlptq_pkg::ID_W-1:0]  entry_id,
    input  logic                        high_priority,
    output logic                        done,
    output logic                        accepted,
    output logic                        served_valid,
    output logic [tlptq_pkg::ID_W-1:0]  served_id,
    output logic                        served_high
);
    import tlptq_pkg::*;

    // Entries that can actually be named on entry_id.
    localparam int SLOTS = (ENTRIES < MAX_IDS) ? ENTRIES : MAX_IDS;
    localparam int IDX_W = $clog2(SLOTS);
    // A pointer carries a null flag in its top bit.
    localparam int PTR_W = IDX_W + 1;
    localparam logic [PTR_W-1:0] NIL = {1'b1, {IDX_W{1'b0}}};
    localparam logic [ID_W:0]    SLOTS_C = (ID_W + 1)'(SLOTS);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;

    logic [PTR_W-1:0] high_head_reg, high_head_next;
    logic [PTR_W-1:0] high_tail_reg, high_tail_next;
    logic [PTR_W-1:0] low_head_reg,  low_head_next;
    logic [PTR_W-1:0] low_tail_reg,  low_tail_next;
    logic [SLOTS-1:0] mark_reg,      mark_next;

    // Item being finished in S_EXEC.
    logic             remove_reg,    remove_next;
    logic             pop_high_reg,  pop_high_next;
    logic [IDX_W-1:0] ent_reg,       ent_next;

    logic             done_reg,      done_next;
    logic             accepted_reg,  accepted_next;
    logic             sv_reg,        sv_next;
    logic [ID_W-1:0]  sid_reg,       sid_next;
    logic             shigh_reg,     shigh_next;

    // Link memories: next and prev pointer of each entry.
    logic [PTR_W-1:0] next_mem [SLOTS];
    logic [PTR_W-1:0] prev_mem [SLOTS];
    logic [PTR_W-1:0] next_rd_reg;
    logic [PTR_W-1:0] prev_rd_reg;

    logic             nmem_we;
    logic [IDX_W-1:0] nmem_waddr;
    logic [PTR_W-1:0] nmem_wdata;
    logic             pmem_we;
    logic [IDX_W-1:0] pmem_waddr;
    logic [PTR_W-1:0] pmem_wdata;
    logic [IDX_W-1:0] rd_addr;

    logic             take;
    logic             id_ok;
    logic [IDX_W-1:0] ent_in;
    logic [PTR_W-1:0] ent_in_ptr;
    logic [PTR_W-1:0] ent_ptr;
    logic             high_any;
    logic             low_any;
    logic [PTR_W-1:0] tail_sel;
    logic [PTR_W-1:0] n_eff;
    logic [PTR_W-1:0] p_eff;

    assign take       = start && (state_reg == S_IDLE);
    assign id_ok      = {1'b0, entry_id} < SLOTS_C;
    assign ent_in     = entry_id[IDX_W-1:0];
    assign ent_in_ptr = {1'b0, ent_in};
    assign ent_ptr    = {1'b0, ent_reg};
    assign high_any   = !high_head_reg[PTR_W-1];
    assign low_any    = !low_head_reg[PTR_W-1];
    assign tail_sel   = high_priority ? high_tail_reg : low_tail_reg;

    // Serve reads the head's links, remove the named entry's links.
    assign rd_addr = (operation == OP_SERVE)
                   ? (high_any ? high_head_reg[IDX_W-1:0] : low_head_reg[IDX_W-1:0])
                   : ent_in;

    // Stale links are masked: a tail has no successor, a head no predecessor.
    assign n_eff = (ent_ptr == high_tail_reg || ent_ptr == low_tail_reg) ? NIL : next_rd_reg;
    assign p_eff = (ent_ptr == high_head_reg || ent_ptr == low_head_reg) ? NIL : prev_rd_reg;

    always_comb
    begin
        state_next     = state_reg;
        high_head_next = high_head_reg;
        high_tail_next = high_tail_reg;
        low_head_next  = low_head_reg;
        low_tail_next  = low_tail_reg;
        mark_next      = mark_reg;
        remove_next    = remove_reg;
        pop_high_next  = pop_high_reg;
        ent_next       = ent_reg;
        done_next      = 1'b0;
        accepted_next  = 1'b0;
        sv_next        = 1'b0;
        sid_next       = '0;
        shigh_next     = 1'b0;
        nmem_we        = 1'b0;
        nmem_waddr     = '0;
        nmem_wdata     = NIL;
        pmem_we        = 1'b0;
        pmem_waddr     = '0;
        pmem_wdata     = NIL;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (operation)
                        OP_ENQUEUE:
                        begin
                            done_next = 1'b1;
                            if (id_ok && !mark_reg[ent_in])
                            begin
                                mark_next[ent_in] = 1'b1;
                                accepted_next     = 1'b1;
                                pmem_we           = 1'b1;
                                pmem_waddr        = ent_in;
                                pmem_wdata        = tail_sel;
                                if (!tail_sel[PTR_W-1])
                                begin
                                    nmem_we    = 1'b1;
                                    nmem_waddr = tail_sel[IDX_W-1:0];
                                    nmem_wdata = ent_in_ptr;
                                end
                                if (high_priority)
                                begin
                                    high_tail_next = ent_in_ptr;
                                    if (!high_any)
                                    begin
                                        high_head_next = ent_in_ptr;
                                    end
                                end
                                else
                                begin
                                    low_tail_next = ent_in_ptr;
                                    if (!low_any)
                                    begin
                                        low_head_next = ent_in_ptr;
                                    end
                                end
                            end
                        end
                        OP_SERVE:
                        begin
                            if (high_any || low_any)
                            begin
                                state_next    = S_EXEC;
                                remove_next   = 1'b0;
                                pop_high_next = high_any;
                                ent_next      = high_any ? high_head_reg[IDX_W-1:0]
                                                         : low_head_reg[IDX_W-1:0];
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (id_ok && mark_reg[ent_in])
                            begin
                                state_next    = S_EXEC;
                                remove_next   = 1'b1;
                                pop_high_next = 1'b0;
                                ent_next      = ent_in;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                state_next         = S_IDLE;
                done_next          = 1'b1;
                mark_next[ent_reg] = 1'b0;
                if (remove_reg)
                begin
                    if (high_tail_reg == ent_ptr) high_tail_next = p_eff;
                    if (high_head_reg == ent_ptr) high_head_next = n_eff;
                    if (low_tail_reg == ent_ptr)  low_tail_next  = p_eff;
                    if (low_head_reg == ent_ptr)  low_head_next  = n_eff;
                    if (!n_eff[PTR_W-1])
                    begin
                        pmem_we    = 1'b1;
                        pmem_waddr = n_eff[IDX_W-1:0];
                        pmem_wdata = p_eff;
                    end
                    if (!p_eff[PTR_W-1])
                    begin
                        nmem_we    = 1'b1;
                        nmem_waddr = p_eff[IDX_W-1:0];
                        nmem_wdata = n_eff;
                    end
                end
                else
                begin
                    sv_next    = 1'b1;
                    sid_next   = ID_W'(ent_reg);
                    shigh_next = pop_high_reg;
                    if (pop_high_reg)
                    begin
                        if (high_tail_reg == ent_ptr)
                        begin
                            high_head_next = NIL;
                            high_tail_next = NIL;
                        end
                        else
                        begin
                            high_head_next = next_rd_reg;
                        end
                    end
                    else
                    begin
                        if (low_tail_reg == ent_ptr)
                        begin
                            low_head_next = NIL;
                            low_tail_next = NIL;
                        end
                        else
                        begin
                            low_head_next = next_rd_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            high_head_reg <= NIL;
            high_tail_reg <= NIL;
            low_head_reg  <= NIL;
            low_tail_reg  <= NIL;
            mark_reg      <= '0;
            remove_reg    <= 1'b0;
            pop_high_reg  <= 1'b0;
            done_reg      <= 1'b0;
            accepted_reg  <= 1'b0;
            sv_reg        <= 1'b0;
            sid_reg       <= '0;
            shigh_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            high_head_reg <= high_head_next;
            high_tail_reg <= high_tail_next;
            low_head_reg  <= low_head_next;
            low_tail_reg  <= low_tail_next;
            mark_reg      <= mark_next;
            remove_reg    <= remove_next;
            pop_high_reg  <= pop_high_next;
            done_reg      <= done_next;
            accepted_reg  <= accepted_next;
            sv_reg        <= sv_next;
            sid_reg       <= sid_next;
            shigh_reg     <= shigh_next;
        end
    end

    // Entry being worked on: payload, no reset.
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    // Link memories: one write, one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (nmem_we)
        begin
            next_mem[nmem_waddr] <= nmem_wdata;
        end
        next_rd_reg <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pmem_we)
        begin
            prev_mem[pmem_waddr] <= pmem_wdata;
        end
        prev_rd_reg <= prev_mem[rd_addr];
    end

    assign busy         = (state_reg == S_EXEC);
    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign served_valid = sv_reg;
    assign served_id    = sid_reg;
    assign served_high  = shigh_reg;

    // A taken item either finishes next cycle or holds the block busy in S_EXEC.
    a_take_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("taken item neither finished nor in progress");

    // S_EXEC never stretches: it always ends with done high and busy low.
    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("second cycle did not finish");

    // A queue's head and tail are null together.
    a_high_ends: assert property (@(posedge clk) disable iff (!rst_n)
        high_head_reg[PTR_W-1] == high_tail_reg[PTR_W-1])
        else $error("high queue head/tail null mismatch");

    a_low_ends: assert property (@(posedge clk) disable iff (!rst_n)
        low_head_reg[PTR_W-1] == low_tail_reg[PTR_W-1])
        else $error("low queue head/tail null mismatch");

    // A popped entry only comes out of the link-read cycle.
    a_serve_src: assert property (@(posedge clk) disable iff (!rst_n)
        served_valid |-> ($past(busy) && !accepted))
        else $error("serve result without link read");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for two_level_priority_task_queue_unit.
// Holds its own model of the two linked queues and checks every done strobe against it.
// Depends on tlptq_pkg and the unit under test.
module testbench;
    import tlptq_pkg::*;

    // op code 3 has no name in the package; the unit must ignore it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int              LOW_Q     = 0;
    localparam int              HIGH_Q    = 1;
    localparam logic [ID_W:0]   NIL       = 7'(MAX_IDS);   // null link, same as the unit
    localparam int              N_RANDOM  = 400;

    typedef struct packed {
        logic            accepted;
        logic            served_valid;
        logic [ID_W-1:0] served_id;
        logic            served_high;
    } sched_result_t;

    // Scheduler model: link tables, waiting marks, heads and tails of both queues,
    // plus the results still owed by the unit, oldest first.
    class sched_model;
        logic [ID_W:0]  next_l [MAX_IDS];
        logic [ID_W:0]  prev_l [MAX_IDS];
        bit             waiting [MAX_IDS];
        logic [ID_W:0]  head [2];
        logic [ID_W:0]  tail [2];
        sched_result_t  owed_results [$];
        int             fail_count;
        int             n_items, n_taken, n_refused, n_served, n_empty, n_unlinked;

        function new();
            for (int i = 0; i < MAX_IDS; i++)
            begin
                next_l[i]  = NIL;
                prev_l[i]  = NIL;
                waiting[i] = 1'b0;
            end
            for (int q = 0; q < 2; q++)
            begin
                head[q] = NIL;
                tail[q] = NIL;
            end
        endfunction

        function void append(logic [ID_W-1:0] e, int q);
            prev_l[e] = tail[q];
            next_l[e] = NIL;
            if (tail[q] != NIL)
                next_l[tail[q][ID_W-1:0]] = {1'b0, e};
            tail[q] = {1'b0, e};
            if (head[q] == NIL)
                head[q] = {1'b0, e};
        endfunction

        function logic [ID_W-1:0] pop(int q);
            logic [ID_W-1:0] e;
            logic [ID_W:0]   n;
            e = head[q][ID_W-1:0];
            n = next_l[e];
            head[q] = n;
            if (n != NIL)
                prev_l[n[ID_W-1:0]] = NIL;
            next_l[e] = NIL;
            prev_l[e] = NIL;
            if (tail[q] == {1'b0, e})
                tail[q] = NIL;
            waiting[e] = 1'b0;
            return e;
        endfunction

        function void unlink(logic [ID_W-1:0] e);
            logic [ID_W:0] n;
            logic [ID_W:0] p;
            n = next_l[e];
            p = prev_l[e];
            for (int q = 0; q < 2; q++)
            begin
                if (tail[q] == {1'b0, e})
                    tail[q] = p;
                if (head[q] == {1'b0, e})
                    head[q] = n;
            end
            if (n != NIL)
                prev_l[n[ID_W-1:0]] = p;
            if (p != NIL)
                next_l[p[ID_W-1:0]] = n;
            next_l[e]  = NIL;
            prev_l[e]  = NIL;
            waiting[e] = 1'b0;
        endfunction

        // an item was taken: update the queues and owe its result
        function void note_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic hi);
            sched_result_t r;
            r = '0;
            n_items++;
            case (op)
                OP_ENQUEUE:
                begin
                    if (!waiting[id])
                    begin
                        waiting[id] = 1'b1;
                        append(id, hi ? HIGH_Q : LOW_Q);
                        r.accepted = 1'b1;
                        n_taken++;
                    end
                    else
                        n_refused++;
                end
                OP_SERVE:
                begin
                    if (head[HIGH_Q] != NIL)
                    begin
                        r.served_id    = pop(HIGH_Q);
                        r.served_valid = 1'b1;
                        r.served_high  = 1'b1;
                        n_served++;
                    end
                    else if (head[LOW_Q] != NIL)
                    begin
                        r.served_id    = pop(LOW_Q);
                        r.served_valid = 1'b1;
                        n_served++;
                    end
                    else
                        n_empty++;
                end
                OP_REMOVE:
                begin
                    if (waiting[id])
                    begin
                        unlink(id);
                        n_unlinked++;
                    end
                end
                default: ;
            endcase
            owed_results.push_back(r);
        endfunction

        function void check_result(logic acc, logic sv, logic [ID_W-1:0] sid, logic sh);
            sched_result_t exp_r;
            if (owed_results.size() == 0)
            begin
                $error("result with nothing owed: accepted=%0d served_valid=%0d id=%0d high=%0d",
                       acc, sv, sid, sh);
                fail_count++;
                return;
            end
            exp_r = owed_results.pop_front();
            if (acc !== exp_r.accepted)
            begin
                $error("accepted: expected %0d, got %0d", exp_r.accepted, acc);
                fail_count++;
            end
            if (sv !== exp_r.served_valid)
            begin
                $error("served_valid: expected %0d, got %0d", exp_r.served_valid, sv);
                fail_count++;
            end
            if (sid !== exp_r.served_id)
            begin
                $error("served_id: expected %0d, got %0d", exp_r.served_id, sid);
                fail_count++;
            end
            if (sh !== exp_r.served_high)
            begin
                $error("served_high: expected %0d, got %0d", exp_r.served_high, sh);
                fail_count++;
            end
        endfunction

        function int owed();
            return owed_results.size();
        endfunction

        // random waiting entry, or -1 if both queues are empty
        function int pick_waiting();
            int cnt;
            int k;
            cnt = 0;
            for (int i = 0; i < MAX_IDS; i++)
                if (waiting[i])
                    cnt++;
            if (cnt == 0)
                return -1;
            k = $urandom_range(0, cnt - 1);
            for (int i = 0; i < MAX_IDS; i++)
            begin
                if (waiting[i])
                begin
                    if (k == 0)
                        return i;
                    k--;
                end
            end
            return -1;
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     operation;
    logic [ID_W-1:0]     entry_id;
    logic                high_priority;
    logic                done;
    logic                accepted;
    logic                served_valid;
    logic [ID_W-1:0]     served_id;
    logic                served_high;

    sched_model          model_h;
    bit                  no_idle;    // set for back-to-back stretches

    two_level_priority_task_queue_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .entry_id      (entry_id),
        .high_priority (high_priority),
        .done          (done),
        .accepted      (accepted),
        .served_valid  (served_valid),
        .served_id     (served_id),
        .served_high   (served_high)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Results cannot be held off: every done cycle is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            model_h.check_result(accepted, served_valid, served_id, served_high);
    end

    // Called at a rising edge; returns at the edge where the item is taken.
    // start is left high there so a zero-gap item follows without a dip.
    task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic hi);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        operation     <= op;
        entry_id      <= id;
        high_priority <= hi;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        model_h.note_item(op, id, hi);
    endtask

    // Sender holds off until the unit has answered every item so far.
    task automatic drain_results();
        start <= 1'b0;
        while (model_h.owed() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic directed_items();
        send_item(OP_SERVE,   6'd0,  1'b1);   // serve with both queues empty
        send_item(OP_REMOVE,  6'd0,  1'b0);   // remove of an entry not waiting
        send_item(OP_UNUSED,  6'd63, 1'b1);   // unused op code, ignored
        send_item(OP_ENQUEUE, 6'd0,  1'b0);
        send_item(OP_ENQUEUE, 6'd63, 1'b1);
        send_item(OP_ENQUEUE, 6'd63, 1'b0);   // already waiting: refused
        send_item(OP_ENQUEUE, 6'd5,  1'b0);
        send_item(OP_ENQUEUE, 6'd42, 1'b1);
        send_item(OP_ENQUEUE, 6'd21, 1'b1);
        send_item(OP_SERVE,   6'd63, 1'b0);   // high first
        send_item(OP_REMOVE,  6'd21, 1'b1);   // tail of high queue
        send_item(OP_REMOVE,  6'd5,  1'b0);   // tail of low queue
        send_item(OP_ENQUEUE, 6'd10, 1'b0);
        send_item(OP_ENQUEUE, 6'd7,  1'b0);
        send_item(OP_REMOVE,  6'd10, 1'b0);   // middle of low queue
        send_item(OP_REMOVE,  6'd0,  1'b0);   // head of low queue
        send_item(OP_SERVE,   6'd0,  1'b0);   // last high entry
        send_item(OP_SERVE,   6'd0,  1'b0);   // falls through to low
        send_item(OP_SERVE,   6'd0,  1'b0);   // empty again
        send_item(OP_REMOVE,  6'd7,  1'b0);   // already served
        send_item(OP_ENQUEUE, 6'd7,  1'b1);   // re-enqueue after serve
        send_item(OP_REMOVE,  6'd7,  1'b1);   // sole entry: head and tail at once
        send_item(OP_SERVE,   6'd0,  1'b0);
        send_item(OP_UNUSED,  6'd0,  1'b0);
    endtask

    // Mostly well-formed traffic: enqueues of random entries, serves and removes of
    // entries that are waiting; the rest duplicate enqueues, stray removes, op 3.
    task automatic random_phase(int n, int enq_pct);
        int              roll;
        int              w;
        logic [ID_W-1:0] id;
        for (int i = 0; i < n; i++)
        begin
            if (i % 32 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            id   = ID_W'($urandom_range(0, MAX_IDS - 1));
            w    = model_h.pick_waiting();
            if (roll < enq_pct)
                send_item(OP_ENQUEUE, id, 1'($urandom_range(0, 1)));
            else if (roll < enq_pct + (100 - enq_pct) / 2)
                send_item(OP_SERVE, id, 1'($urandom_range(0, 1)));
            else if (roll < 92)
                send_item(OP_REMOVE, (w >= 0 && $urandom_range(0, 4) != 0) ? ID_W'(w) : id,
                          1'($urandom_range(0, 1)));
            else if (roll < 97 && w >= 0)
                send_item(OP_ENQUEUE, ID_W'(w), 1'($urandom_range(0, 1)));
            else
                send_item(OP_UNUSED, id, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        model_h        = new();
        no_idle        = 1'b0;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        operation     <= OP_ENQUEUE;
        entry_id      <= '0;
        high_priority <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        drain_results();

        // fill deep, churn, then empty out, so queues both grow long and run dry
        random_phase(N_RANDOM / 4, 70);
        drain_results();
        random_phase(N_RANDOM / 4, 50);
        random_phase(N_RANDOM / 4, 35);
        drain_results();
        random_phase(N_RANDOM / 4, 20);

        drain_results();
        repeat (5) @(posedge clk);

        $display("run covered %0d items: %0d enqueues taken, %0d refused, %0d served",
                 model_h.n_items, model_h.n_taken, model_h.n_refused, model_h.n_served);
        $display("  plus %0d serves of empty queues and %0d entries unlinked by remove",
                 model_h.n_empty, model_h.n_unlinked);
        if (model_h.fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
